// ===== rtl/lcsw_pkg.sv =====
package lcsw_pkg;

   localparam int KEY_W = 32;

   typedef struct packed {
      logic load;
      logic lookup;
      logic update;
   } lcsw_cmd_type;

endpackage

// ===== rtl/lcsw_ctrl.sv =====
module lcsw_ctrl
   import lcsw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output lcsw_cmd_type cmd,
   output logic         rsp_valid
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/lcsw_dpath.sv =====
module lcsw_dpath
   import lcsw_pkg::*;
#(
   parameter int WAYS     = 8,
   parameter int KEY_BITS = 32
)
(
   input  logic             clock,
   input  logic             reset,
   input  lcsw_cmd_type     cmd,
   input  logic [KEY_W-1:0] req_key,
   output logic             rsp_hit,
   output logic             rsp_evicted,
   output logic [KEY_W-1:0] rsp_evicted_key
);

   localparam int TAG_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WAYS - 1);

   logic [TAG_W-1:0] tag_ff [WAYS];
   logic [AGE_W-1:0] age_ff [WAYS];
   logic [AGE_W-1:0] age_in [WAYS];
   logic [WAYS-1:0]  valid_ff, valid_in;
   logic [TAG_W-1:0] key_ff;

   // lookup results
   logic [WAYS-1:0]  hit_vec_ff, hit_vec_in;
   logic [WAYS-1:0]  free_vec_ff, free_vec_in;
   logic [WAYS-1:0]  lru_vec_ff, lru_vec_in;
   logic             hit_any_ff, free_any_ff;
   logic [AGE_W-1:0] hit_age_ff, hit_age_in;
   logic [TAG_W-1:0] lru_tag_ff, lru_tag_in;

   logic [WAYS-1:0]  match_raw, lru_raw;
   logic [WAYS-1:0]  target;

   logic             rsp_hit_ff, rsp_evicted_ff;
   logic [KEY_W-1:0] rsp_evicted_key_ff;

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         match_raw[i] = valid_ff[i] && (tag_ff[i] == key_ff);
         lru_raw[i]   = valid_ff[i] && (age_ff[i] == AGE_OLDEST);
      end
      hit_vec_in  = match_raw & (~match_raw + 1'b1);
      free_vec_in = ~valid_ff & (valid_ff + 1'b1);
      lru_vec_in  = lru_raw & (~lru_raw + 1'b1);
      hit_age_in  = '0;
      lru_tag_in  = '0;
      for (int i = 0; i < WAYS; i++) begin
         hit_age_in = hit_age_in | (age_ff[i] & {AGE_W{hit_vec_in[i]}});
         lru_tag_in = lru_tag_in | (tag_ff[i] & {TAG_W{lru_vec_in[i]}});
      end
   end

   always_comb begin
      if (hit_any_ff) begin
         target = hit_vec_ff;
      end else if (free_any_ff) begin
         target = free_vec_ff;
      end else begin
         target = lru_vec_ff;
      end
      valid_in = valid_ff;
      for (int i = 0; i < WAYS; i++) begin
         age_in[i] = age_ff[i];
         if (target[i]) begin
            age_in[i] = '0;
         end else if (valid_ff[i] && (!hit_any_ff || age_ff[i] < hit_age_ff)) begin
            age_in[i] = age_ff[i] + 1'b1;
         end
      end
      if (!hit_any_ff) begin
         valid_in = valid_ff | target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < WAYS; i++) begin
            age_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         valid_ff <= valid_in;
         for (int i = 0; i < WAYS; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && !hit_any_ff) begin
         for (int i = 0; i < WAYS; i++) begin
            if (target[i]) begin
               tag_ff[i] <= key_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= TAG_W'(req_key);
      end
      if (cmd.lookup) begin
         hit_vec_ff  <= hit_vec_in;
         free_vec_ff <= free_vec_in;
         lru_vec_ff  <= lru_vec_in;
         hit_any_ff  <= |match_raw;
         free_any_ff <= ~&valid_ff;
         hit_age_ff  <= hit_age_in;
         lru_tag_ff  <= lru_tag_in;
      end
      if (cmd.update) begin
         rsp_hit_ff         <= hit_any_ff;
         rsp_evicted_ff     <= !hit_any_ff && !free_any_ff;
         rsp_evicted_key_ff <= (!hit_any_ff && !free_any_ff) ? KEY_W'(lru_tag_ff) : '0;
      end
   end

   assign rsp_hit         = rsp_hit_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

endmodule

// ===== rtl/lru_cache_set_write_top.sv =====
// One fully associative cache set with least-recently-used replacement. Each
// request writes req_key: a hit makes that way most recently used, a miss fills
// the lowest free way or, when the set is full, evicts the least recently used
// way and reports its tag. A request is taken when start is high and busy is
// low; its result appears on the rsp_ ports with rsp_valid for one cycle, three
// clocks after acceptance, and must be captured then since it cannot be held
// off. A new request can be accepted every three cycles: one cycle loads the
// key, one compares it against all ways, one updates tags and recency ranks.
module lru_cache_set_write_top
   import lcsw_pkg::*;
#(
   parameter int WAYS     = 8,
   parameter int KEY_BITS = 32
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [KEY_W-1:0] req_key,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic             rsp_evicted,
   output logic [KEY_W-1:0] rsp_evicted_key
);

   lcsw_cmd_type cmd;

   lcsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   lcsw_dpath #(
      .WAYS     (WAYS),
      .KEY_BITS (KEY_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_key         (req_key),
      .rsp_hit         (rsp_hit),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key)
   );

endmodule

// ===== rtl/lcsw_check.sv =====
module lcsw_check
   import lcsw_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic             rsp_hit,
   input logic             rsp_evicted,
   input logic [KEY_W-1:0] rsp_evicted_key
);

   logic accept;
   assign accept = start && !busy;

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("request without response");

   a_resp_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("response without request");

   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after accepting a request");

   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> !rsp_hit)
      else $error("eviction reported on a hit");

   a_evict_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted) |-> (rsp_evicted_key == '0))
      else $error("evicted key nonzero without eviction");

endmodule

bind lru_cache_set_write_top lcsw_check u_check (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_hit         (rsp_hit),
   .rsp_evicted     (rsp_evicted),
   .rsp_evicted_key (rsp_evicted_key)
);

// ===== verif/testbench.sv =====
import lcsw_pkg::*;

class lru_set_scoreboard_type;

   typedef struct packed {
      logic             hit;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
   } write_outcome_type;

   int               ways;
   logic [KEY_W-1:0] way_tag[];
   bit               way_valid[];
   int               way_age[];
   logic [KEY_W-1:0] key_mask;

   write_outcome_type outcomes_due[$];
   int writes;
   int hits;
   int evictions;
   int errors;

   function new(int n_ways, int key_bits);
      ways      = n_ways;
      way_tag   = new[n_ways];
      way_valid = new[n_ways];
      way_age   = new[n_ways];
      for (int i = 0; i < ways; i++) begin
         way_tag[i]   = '0;
         way_valid[i] = 1'b0;
         way_age[i]   = 0;
      end
      key_mask = '0;
      for (int b = 0; b < KEY_W; b++) begin
         if (b < key_bits) key_mask[b] = 1'b1;
      end
      writes    = 0;
      hits      = 0;
      evictions = 0;
      errors    = 0;
   endfunction

   function write_outcome_type predict_write(logic [KEY_W-1:0] key);
      logic [KEY_W-1:0]  k;
      int                hit_way;
      int                free_way;
      int                old_way;
      int                slot;
      int                old_age;
      int                rank;
      write_outcome_type res;
      k        = key & key_mask;
      hit_way  = -1;
      free_way = -1;
      old_way  = -1;
      old_age  = 0;
      res      = '0;
      for (int i = 0; i < ways; i++) begin
         if (way_valid[i]) begin
            if (hit_way < 0 && way_tag[i] == k) hit_way = i;
            if (old_way < 0 || way_age[i] > old_age) begin
               old_way = i;
               old_age = way_age[i];
            end
         end else if (free_way < 0) begin
            free_way = i;
         end
      end
      if (hit_way >= 0) begin
         res.hit = 1'b1;
         slot = hit_way;
         rank = way_age[hit_way];
         for (int i = 0; i < ways; i++) begin
            if (way_valid[i] && way_age[i] < rank) way_age[i]++;
         end
      end else begin
         if (free_way >= 0) begin
            slot = free_way;
            for (int i = 0; i < ways; i++) begin
               if (way_valid[i]) way_age[i]++;
            end
         end else begin
            slot = old_way;
            res.evicted     = 1'b1;
            res.evicted_key = way_tag[old_way];
            for (int i = 0; i < ways; i++) begin
               if (way_valid[i] && i != old_way && way_age[i] < old_age) way_age[i]++;
            end
         end
         way_tag[slot]   = k;
         way_valid[slot] = 1'b1;
      end
      way_age[slot] = 0;
      return res;
   endfunction

   function void note_write(logic [KEY_W-1:0] key);
      write_outcome_type res;
      res = predict_write(key);
      writes++;
      if (res.hit) hits++;
      if (res.evicted) evictions++;
      outcomes_due.insert(outcomes_due.size(), res);
   endfunction

   function void check_result(logic hit, logic evicted, logic [KEY_W-1:0] evicted_key);
      write_outcome_type exp;
      if (outcomes_due.size() == 0) begin
         $display("%0t: unexpected response hit=%0b evicted=%0b evicted_key=%h",
                  $time, hit, evicted, evicted_key);
         errors++;
         return;
      end
      exp = outcomes_due.pop_front();
      if (hit !== exp.hit) begin
         $display("%0t: hit mismatch, expected %0b, got %0b", $time, exp.hit, hit);
         errors++;
      end
      if (evicted !== exp.evicted) begin
         $display("%0t: evicted mismatch, expected %0b, got %0b",
                  $time, exp.evicted, evicted);
         errors++;
      end
      if (evicted_key !== exp.evicted_key) begin
         $display("%0t: evicted_key mismatch, expected %h, got %h",
                  $time, exp.evicted_key, evicted_key);
         errors++;
      end
   endfunction

   function int pending();
      return outcomes_due.size();
   endfunction

endclass

module testbench;

   localparam int WAYS       = 8;
   localparam int KEY_BITS   = 32;
   localparam int STALL_MAX  = 2000;
   localparam int RAND_ITEMS = 450;

   logic             clock;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic [KEY_W-1:0] req_key = '0;
   logic             busy;
   logic             rsp_valid;
   logic             rsp_hit;
   logic             rsp_evicted;
   logic [KEY_W-1:0] rsp_evicted_key;

   lru_set_scoreboard_type sb = new(WAYS, KEY_BITS);

   int  idle_cycles = 0;
   int  drains = 0;
   bit  no_idle = 1'b0;

   lru_cache_set_write_top #(
      .WAYS     (WAYS),
      .KEY_BITS (KEY_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // accepted requests, responses and the stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (start && !busy) begin
            sb.note_write(req_key);
         end
         if (rsp_valid) begin
            sb.check_result(rsp_hit, rsp_evicted, rsp_evicted_key);
         end
         if (idle_cycles >= STALL_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic send_write(input logic [KEY_W-1:0] key, input int gap);
      if (gap > 0) begin
         start   <= 1'b0;
         req_key <= $urandom;
         repeat (gap) @(posedge clock);
      end
      start   <= 1'b1;
      req_key <= key;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_all_results();
      start   <= 1'b0;
      req_key <= $urandom;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      logic [KEY_W-1:0] directed[$];
      logic [KEY_W-1:0] key_pool[$];
      logic [KEY_W-1:0] key;
      int               r;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero, hit, all ones, fill to full, hit on LRU, evict all ones,
      // hit on MRU, then evict through the set until zero and then DEADBEEF are evicted
      directed = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                   32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                   32'hFEDC_BA98, 32'h0000_0000, 32'hDEAD_BEEF, 32'hDEAD_BEEF,
                   32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC,
                   32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0002, 32'h1111_1111};
      foreach (directed[i]) send_write(directed[i], 0);
      wait_all_results();
      drains++;

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 50 == 0) no_idle = ($urandom_range(3) == 0);
         if (n % 60 == 0) begin
            key_pool.delete();
            r = $urandom_range(14, 5);
            repeat (r) key_pool.insert(key_pool.size(), $urandom);
         end
         if (n % 110 == 109) begin
            wait_all_results();
            drains++;
         end
         r = $urandom_range(99);
         if (r < 80) key = key_pool[$urandom_range(key_pool.size() - 1)];
         else if (r < 90) key = $urandom;
         else key = key_pool[0] ^ (32'h1 << $urandom_range(KEY_W - 1));
         send_write(key, pick_gap());
      end

      wait_all_results();
      drains++;
      repeat (10) @(posedge clock);

      $display("%0d write requests checked: %0d hits, %0d evictions, %0d fills of free ways",
               sb.writes, sb.hits, sb.evictions, sb.writes - sb.hits - sb.evictions);
      $display("sender fully drained the set %0d times; random gaps on the request side",
               drains);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.errors, sb.pending());
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lcsw_pkg.sv
rtl/lcsw_ctrl.sv
rtl/lcsw_dpath.sv
rtl/lru_cache_set_write_top.sv
rtl/lcsw_check.sv
verif/testbench.sv
